>>> sv/rdl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdl_pkg
// Shared types, constants and the CRC-8 byte update for the register link.
// ----------------------------------------------------------------------------
package rdl_pkg;

  localparam logic [7:0] SYNC_BYTE  = 8'h05;
  localparam logic [7:0] CRC_POLY   = 8'h07;
  localparam logic [7:0] REPLY_NODE = 8'hFF;

  // byte positions inside a request
  localparam logic [2:0] WRITE_LAST_IDX = 3'd7;
  localparam logic [2:0] READ_LAST_IDX  = 3'd3;
  localparam logic [2:0] RX_LAST_IDX    = 3'd7;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_RX    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_VERDICT = 2'd2
  } cmd_kind_e;

  typedef enum logic {
    OUT_TX      = 1'b0,
    OUT_VERDICT = 1'b1
  } out_kind_e;

  // one unit of work for the back end
  typedef struct packed {
    cmd_kind_e   kind;
    logic [6:0]  addr;
    logic [31:0] data;   // write value or reply payload
    logic        ok;
  } cmd_t;

  // LSB-first CRC-8 update
  function automatic logic [7:0] crc_feed(input logic [7:0] crc_in, input logic [7:0] byte_in);
    logic [7:0] crc;
    logic [7:0] b;
    logic       top;
    crc = crc_in;
    b   = byte_in;
    for (int i = 0; i < 8; i++) begin
      top = crc[7] ^ b[0];
      crc = {crc[6:0], 1'b0};
      if (top) begin
        crc = crc ^ CRC_POLY;
      end
      b = {1'b0, b[7:1]};
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

>>> sv/rdl_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdl_front
// Accepts input transactions, tracks the reply receiver and queues commands.
// ----------------------------------------------------------------------------
module rdl_front
  import rdl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [6:0]  reg_address_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [7:0]  rx_byte_i,
  output cmd_t             cmd_o,
  output logic             cmd_push_o
);

  logic        pending_q, pending_d;
  logic [6:0]  exp_addr_q, exp_addr_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  node_q, node_d;
  logic [7:0]  addrb_q, addrb_d;
  logic [31:0] payload_q, payload_d;

  always_comb begin
    pending_d  = pending_q;
    exp_addr_d = exp_addr_q;
    cnt_d      = cnt_q;
    crc_d      = crc_q;
    node_d     = node_q;
    addrb_d    = addrb_q;
    payload_d  = payload_q;
    cmd_push_o = 1'b0;
    cmd_o.kind = CMD_WRITE;
    cmd_o.addr = reg_address_i;
    cmd_o.data = write_data_i;
    cmd_o.ok   = 1'b0;
    if (accept_i) begin
      case (kind_e'(kind_i))
        KIND_WRITE: begin
          cmd_push_o = 1'b1;
        end
        KIND_READ: begin
          cmd_push_o = 1'b1;
          cmd_o.kind = CMD_READ;
          // rearm the receiver for this request
          pending_d  = 1'b1;
          exp_addr_d = reg_address_i;
          cnt_d      = '0;
          crc_d      = '0;
          node_d     = '0;
          addrb_d    = '0;
          payload_d  = '0;
        end
        KIND_RX: begin
          if (pending_q) begin
            if (cnt_q == RX_LAST_IDX) begin
              cmd_push_o = 1'b1;
              cmd_o.kind = CMD_VERDICT;
              cmd_o.data = payload_q;
              cmd_o.ok   = (node_q == REPLY_NODE) && (addrb_q == {1'b0, exp_addr_q}) &&
                           (rx_byte_i == crc_q);
              pending_d  = 1'b0;
              cnt_d      = '0;
            end else begin
              crc_d = crc_feed(crc_q, rx_byte_i);
              if (cnt_q == 3'd1) begin
                node_d = rx_byte_i;
              end else if (cnt_q == 3'd2) begin
                addrb_d = rx_byte_i;
              end else if (cnt_q >= 3'd3) begin
                payload_d = {payload_q[23:0], rx_byte_i};
              end
              cnt_d = cnt_q + 3'd1;
            end
          end
        end
        default: begin
          // unused code: drop
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= 1'b0;
      exp_addr_q <= '0;
      cnt_q      <= '0;
      crc_q      <= '0;
      node_q     <= '0;
      addrb_q    <= '0;
      payload_q  <= '0;
    end else begin
      pending_q  <= pending_d;
      exp_addr_q <= exp_addr_d;
      cnt_q      <= cnt_d;
      crc_q      <= crc_d;
      node_q     <= node_d;
      addrb_q    <= addrb_d;
      payload_q  <= payload_d;
    end
  end

`ifndef SYNTHESIS
  a_verdict_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_push_o && cmd_o.kind == CMD_VERDICT) |-> pending_q)
    else $error("verdict queued with no read pending");

  a_read_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && kind_i == KIND_READ) |=> (pending_q && cnt_q == 3'd0))
    else $error("read did not rearm the receiver");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pending_q |-> (cnt_q == 3'd0))
    else $error("receive count nonzero while idle");
`endif

endmodule
`default_nettype wire

>>> sv/rdl_cmd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdl_cmd_fifo
// Short command queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module rdl_cmd_fifo
  import rdl_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output cmd_t      rdata_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == CntFull);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command queue underflow");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("command queue count out of range");
`endif

endmodule
`default_nettype wire

>>> sv/rdl_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rdl_back
// Byte sequencer: expands queued commands into transmit bytes with CRC, or
// a reply verdict, into a one-entry output register.
// ----------------------------------------------------------------------------
module rdl_back
  import rdl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  node_address_i,
  input  wire cmd_t        cmd_i,
  input  wire logic        cmd_valid_i,
  output logic             cmd_pop_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output logic             out_kind_o,
  output logic [7:0]       tx_byte_o,
  output logic             last_o,
  output logic             reply_ok_o,
  output logic [31:0]      reply_data_o
);

  logic        out_valid_q;
  logic        out_kind_q;
  logic [7:0]  tx_byte_q;
  logic        last_q;
  logic        reply_ok_q;
  logic [31:0] reply_data_q;

  logic [2:0]  idx_q, idx_d;
  logic [7:0]  crc_q, crc_d;

  logic        load;
  logic        emit;
  logic        is_verdict;
  logic        req_last;
  logic [7:0]  req_byte;

  assign load       = !out_valid_q || pop_i;
  assign emit       = cmd_valid_i && load;
  assign is_verdict = (cmd_i.kind == CMD_VERDICT);
  assign req_last   = (cmd_i.kind == CMD_WRITE) ? (idx_q == WRITE_LAST_IDX)
                                                : (idx_q == READ_LAST_IDX);

  always_comb begin
    if (req_last) begin
      req_byte = crc_q;
    end else begin
      case (idx_q)
        3'd0:    req_byte = SYNC_BYTE;
        3'd1:    req_byte = node_address_i;
        3'd2:    req_byte = {cmd_i.kind == CMD_WRITE, cmd_i.addr};
        3'd3:    req_byte = cmd_i.data[31:24];
        3'd4:    req_byte = cmd_i.data[23:16];
        3'd5:    req_byte = cmd_i.data[15:8];
        3'd6:    req_byte = cmd_i.data[7:0];
        default: req_byte = crc_q;
      endcase
    end
  end

  always_comb begin
    idx_d     = idx_q;
    crc_d     = crc_q;
    cmd_pop_o = 1'b0;
    if (emit) begin
      if (is_verdict || req_last) begin
        // command done: release it and restart the sequencer
        cmd_pop_o = 1'b1;
        idx_d     = '0;
        crc_d     = '0;
      end else begin
        idx_d = idx_q + 3'd1;
        crc_d = crc_feed(crc_q, req_byte);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      crc_q       <= '0;
    end else begin
      idx_q <= idx_d;
      crc_q <= crc_d;
      if (load) begin
        out_valid_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (is_verdict) begin
        out_kind_q   <= OUT_VERDICT;
        tx_byte_q    <= '0;
        last_q       <= 1'b0;
        reply_ok_q   <= cmd_i.ok;
        reply_data_q <= cmd_i.data;
      end else begin
        out_kind_q   <= OUT_TX;
        tx_byte_q    <= req_byte;
        last_q       <= req_last;
        reply_ok_q   <= 1'b0;
        reply_data_q <= '0;
      end
    end
  end

  assign empty_o      = !out_valid_q;
  assign out_kind_o   = out_kind_q;
  assign tx_byte_o    = tx_byte_q;
  assign last_o       = last_q;
  assign reply_ok_o   = reply_ok_q;
  assign reply_data_o = reply_data_q;

`ifndef SYNTHESIS
  a_last_only_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> (out_kind_q == OUT_TX))
    else $error("last flag on a verdict");

  a_read_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_i.kind == CMD_READ) |-> (idx_q <= READ_LAST_IDX))
    else $error("read request ran past its CRC byte");

  a_idle_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_valid_i |-> (idx_q == 3'd0 && crc_q == 8'd0))
    else $error("sequencer not at rest with no command");
`endif

endmodule
`default_nettype wire

>>> sv/register_datagram_link_crc8_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// register_datagram_link_crc8_core
// Host side of a single-wire UART register link with CRC-8 (poly 0x07).
// ----------------------------------------------------------------------------
// Input transactions are taken one per cycle while the command queue has
// room; received reply bytes are checked in the cycle they are accepted and
// only the eighth one queues a verdict. The byte sequencer behind the queue
// delivers one result per cycle if its output register is free or popped:
// a write request gives eight bytes, a read four, a verdict one, so it sets
// sustained request throughput. The queue holds CmdDepth commands, the one
// being sequenced included, and one result waits in the output register.
module register_datagram_link_crc8_core
  import rdl_pkg::*;
#(
  parameter int unsigned CmdDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [6:0]  reg_address_i,
  input  wire logic [31:0] write_data_i,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic             out_kind_o,
  output logic [7:0]       tx_byte_o,
  output logic             last_o,
  output logic             reply_ok_o,
  output logic [31:0]      reply_data_o
);

  logic [7:0] node_address_q;
  logic       accept;
  cmd_t       push_cmd;
  logic       cmd_push;
  cmd_t       head_cmd;
  logic       cmd_empty;
  logic       cmd_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_address_q <= '0;
    end else if (cfg_we_i) begin
      node_address_q <= cfg_wdata_i;
    end
  end

  assign accept = push_i && !full_o;

  rdl_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .reg_address_i (reg_address_i),
    .write_data_i  (write_data_i),
    .rx_byte_i     (rx_byte_i),
    .cmd_o         (push_cmd),
    .cmd_push_o    (cmd_push)
  );

  rdl_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (push_cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop),
    .rdata_o (head_cmd),
    .empty_o (cmd_empty)
  );

  rdl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .node_address_i (node_address_q),
    .cmd_i          (head_cmd),
    .cmd_valid_i    (!cmd_empty),
    .cmd_pop_o      (cmd_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .out_kind_o     (out_kind_o),
    .tx_byte_o      (tx_byte_o),
    .last_o         (last_o),
    .reply_ok_o     (reply_ok_o),
    .reply_data_o   (reply_data_o)
  );

endmodule
`default_nettype wire
